### hw/rtl/compass_heading_atan2_core_defines.svh
// Assertion macros for the compass heading core and its checker.
// Included by the checker file; needs no other file.
`ifndef COMPASS_HEADING_ATAN2_CORE_DEFINES_SVH
`define COMPASS_HEADING_ATAN2_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define CHA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define CHA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define CHA_ASSERT_RESET(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/cha_pkg.sv
// Shared types, constants and the CORDIC angle table for the compass heading core.
// Used by every module of the core; depends on nothing.
`default_nettype none
package cha_pkg;

    localparam int ITERATIONS_DEF = 16;
    localparam int ANGLE_BITS_DEF = 16;
    localparam int RAW_W          = 16;
    localparam int AXIS_W         = 18;
    localparam int GUARD_BITS     = 8;
    localparam int XY_W           = AXIS_W + GUARD_BITS + 2;
    localparam int TABLE_LEN      = 24;
    localparam int HEADING_W      = 16;
    localparam logic [AXIS_W-1:0] CENTER = 18'd32768;

    // atan(2^-i) as a binary angle, 2^32 units per turn.
    localparam logic [TABLE_LEN-1:0][31:0] ATAN_TAB = {
        32'h00000051, 32'h000000A3, 32'h00000146, 32'h0000028C,
        32'h00000518, 32'h00000A30, 32'h0000145F, 32'h000028BE,
        32'h0000517D, 32'h0000A2FA, 32'h000145F3, 32'h00028BE6,
        32'h000517CC, 32'h000A2F98, 32'h00145F2F, 32'h0028BE53,
        32'h00517C55, 32'h00A2F61E, 32'h0145D7E1, 32'h028B0D43,
        32'h051111D4, 32'h09FB385B, 32'h12E4051E, 32'h20000000
    };

    // Vector state handed from cell to cell.
    typedef struct packed {
        logic                   zero;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
    } vec_t;

    // Table entry rounded to nearest, ties up, to ab bits.
    function automatic logic [31:0] atan_const(input logic [4:0] idx, input int ab);
        logic [32:0] t;
        t = {1'b0, ATAN_TAB[idx]} + (33'd1 << (31 - ab));
        return 32'(t >> (32 - ab));
    endfunction

endpackage
`default_nettype wire

### hw/rtl/compass_heading_atan2_core.sv
// Top level of the compass heading core: input fold, CORDIC cell chain, output rounding.
// Depends on cha_pkg, cha_prerotate, cha_cell and cha_round.
`default_nettype none
// The core turns one raw magnetometer X/Y pair (offset binary, 32768 is zero
// field) into a heading, a 16-bit binary angle where 65536 units make one
// full turn, 0 points along +X and the angle grows toward +Y. Both axes are
// centered and the signed axis_offset register is added to each before the
// angle is found by CORDIC vectoring; a zero vector reads as heading 0.
// The datapath is a chain of ITERATIONS rotation cells between an
// input fold stage and an output rounding register, so the core takes one
// item every clock cycle while the output is not stalled. An item passes
// through ITERATIONS + 2 registers: the fold stage, the cells and the
// rounding register. Each stage holds its item until the next stage can
// take it, so empty stages keep filling while a result waits on m_tready.
// axis_offset may be written only while no item is in flight.
module compass_heading_atan2_core #(
    parameter int ITERATIONS = cha_pkg::ITERATIONS_DEF,
    parameter int ANGLE_BITS = cha_pkg::ANGLE_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input item channel.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [15:0] raw_x, [31:16] raw_y
    // Result item channel.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [15:0] heading
    // Offset register write port.
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata  // axis_offset, signed raw LSBs
);
    import cha_pkg::*;

    logic signed [RAW_W-1:0] axis_offset_reg;

    // Stage k of the chain feeds cell k; index ITERATIONS feeds the output.
    vec_t                  vec_w   [ITERATIONS+1];
    logic [ANGLE_BITS-1:0] z_w     [ITERATIONS+1];
    logic                  valid_w [ITERATIONS+1];
    logic                  ready_w [ITERATIONS+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axis_offset_reg <= '0;
        end else if (cfg_we) begin
            axis_offset_reg <= $signed(cfg_wdata);
        end
    end

    cha_prerotate #(
        .ANGLE_BITS(ANGLE_BITS)
    ) u_prerotate (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .raw_x     (s_tdata[15:0]),
        .raw_y     (s_tdata[31:16]),
        .offset    (axis_offset_reg),
        .out_valid (valid_w[0]),
        .out_ready (ready_w[0]),
        .out_vec   (vec_w[0]),
        .out_z     (z_w[0])
    );

    // One micro-rotation per cell; the cell index sets its shift and angle step.
    generate
        for (genvar k = 0; k < ITERATIONS; k++) begin : g_cell
            cha_cell #(
                .STAGE      (k),
                .ANGLE_BITS (ANGLE_BITS)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .in_valid  (valid_w[k]),
                .in_ready  (ready_w[k]),
                .in_vec    (vec_w[k]),
                .in_z      (z_w[k]),
                .out_valid (valid_w[k+1]),
                .out_ready (ready_w[k+1]),
                .out_vec   (vec_w[k+1]),
                .out_z     (z_w[k+1])
            );
        end
    endgenerate

    cha_round #(
        .ANGLE_BITS(ANGLE_BITS)
    ) u_round (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (valid_w[ITERATIONS]),
        .in_ready    (ready_w[ITERATIONS]),
        .in_zero     (vec_w[ITERATIONS].zero),
        .in_z        (z_w[ITERATIONS]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_heading (m_tdata)
    );

endmodule
`default_nettype wire

### hw/rtl/cha_prerotate.sv
// Input stage: centers both axes, adds the offset and folds the vector into the
// right half-plane. Depends on cha_pkg.
`default_nettype none
module cha_prerotate #(
    parameter int ANGLE_BITS = cha_pkg::ANGLE_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [cha_pkg::RAW_W-1:0]    raw_x,
    input  wire logic [cha_pkg::RAW_W-1:0]    raw_y,
    input  wire logic signed [cha_pkg::RAW_W-1:0] offset,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output cha_pkg::vec_t                     out_vec,
    output logic [ANGLE_BITS-1:0]             out_z
);
    import cha_pkg::*;

    localparam logic [ANGLE_BITS-1:0] QUARTER =
        {{(ANGLE_BITS-1){1'b0}}, 1'b1} << (ANGLE_BITS - 2);

    logic                   valid_reg, valid_next;
    vec_t                   vec_reg, vec_next;
    logic [ANGLE_BITS-1:0]  z_reg, z_next;
    logic signed [AXIS_W-1:0] ax, ay;
    logic signed [XY_W-1:0]   sx, sy;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        ax = $signed({2'b00, raw_x} - CENTER + {{(AXIS_W-RAW_W){offset[RAW_W-1]}}, offset});
        ay = $signed({2'b00, raw_y} - CENTER + {{(AXIS_W-RAW_W){offset[RAW_W-1]}}, offset});
        sx = $signed({{(XY_W-AXIS_W-GUARD_BITS){ax[AXIS_W-1]}}, ax, {GUARD_BITS{1'b0}}});
        sy = $signed({{(XY_W-AXIS_W-GUARD_BITS){ay[AXIS_W-1]}}, ay, {GUARD_BITS{1'b0}}});
        vec_next.zero = (ax == '0) && (ay == '0);
        vec_next.x    = sx;
        vec_next.y    = sy;
        z_next        = '0;
        if (sx < 0) begin
            if (sy >= 0) begin
                vec_next.x = sy;
                vec_next.y = -sx;
                z_next     = QUARTER;
            end else begin
                vec_next.x = -sy;
                vec_next.y = sx;
                z_next     = -QUARTER;
            end
        end
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            vec_reg <= vec_next;
            z_reg   <= z_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;
    assign out_z     = z_reg;

endmodule
`default_nettype wire

### hw/rtl/cha_cell.sv
// One CORDIC vectoring micro-rotation with its own pipeline register.
// Depends on cha_pkg.
`default_nettype none
module cha_cell #(
    parameter int STAGE      = 0,
    parameter int ANGLE_BITS = cha_pkg::ANGLE_BITS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire cha_pkg::vec_t     in_vec,
    input  wire logic [ANGLE_BITS-1:0] in_z,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output cha_pkg::vec_t          out_vec,
    output logic [ANGLE_BITS-1:0]  out_z
);
    import cha_pkg::*;

    localparam logic [ANGLE_BITS-1:0] ATAN_K =
        ANGLE_BITS'(atan_const(5'(STAGE), ANGLE_BITS));

    logic                  valid_reg, valid_next;
    vec_t                  vec_reg, vec_next;
    logic [ANGLE_BITS-1:0] z_reg, z_next;
    logic signed [XY_W-1:0] xs, ys;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        xs            = in_vec.x >>> STAGE;
        ys            = in_vec.y >>> STAGE;
        vec_next.zero = in_vec.zero;
        // A y of exactly zero rotates the same way as a negative y.
        if (in_vec.y > 0) begin
            vec_next.x = in_vec.x + ys;
            vec_next.y = in_vec.y - xs;
            z_next     = in_z + ATAN_K;
        end else begin
            vec_next.x = in_vec.x - ys;
            vec_next.y = in_vec.y + xs;
            z_next     = in_z - ATAN_K;
        end
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            vec_reg <= vec_next;
            z_reg   <= z_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;
    assign out_z     = z_reg;

endmodule
`default_nettype wire

### hw/rtl/cha_round.sv
// Output register: scales the angle to 16 bits and forces zero vectors to 0.
// Depends on cha_pkg.
`default_nettype none
module cha_round #(
    parameter int ANGLE_BITS = cha_pkg::ANGLE_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  in_zero,
    input  wire logic [ANGLE_BITS-1:0] in_z,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [cha_pkg::HEADING_W-1:0] out_heading
);
    import cha_pkg::*;

    logic                 valid_reg, valid_next;
    logic [HEADING_W-1:0] heading_reg, heading_next;
    logic [HEADING_W-1:0] scaled;

    generate
        if (ANGLE_BITS > HEADING_W) begin : g_round
            localparam int SH = ANGLE_BITS - HEADING_W;
            logic [ANGLE_BITS:0] sum;
            // Round to nearest, ties up; a carry out to a full turn drops off.
            assign sum    = {1'b0, in_z} + ((ANGLE_BITS+1)'(1) << (SH - 1));
            assign scaled = sum[SH+HEADING_W-1:SH];
        end else if (ANGLE_BITS == HEADING_W) begin : g_same
            assign scaled = in_z;
        end else begin : g_widen
            assign scaled = {in_z, {(HEADING_W-ANGLE_BITS){1'b0}}};
        end
    endgenerate

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        heading_next = in_zero ? '0 : scaled;
        valid_next   = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            heading_reg <= heading_next;
        end
    end

    assign out_valid   = valid_reg;
    assign out_heading = heading_reg;

endmodule
`default_nettype wire

### hw/rtl/cha_checker.sv
// Port-level checker for the compass heading core and the bind that attaches it.
// Depends on compass_heading_atan2_core_defines.svh and the top level.
`default_nettype none
`include "compass_heading_atan2_core_defines.svh"
module cha_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata
);
    // A result that is not taken stays put.
    `CHA_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // The input side only backs up when the result side is stalled.
    `CHA_ASSERT_NOW(a_backpressure, !s_tready, m_tvalid && !m_tready, "input stalled without output stall")

    // Reset empties the chain, so no result is shown right after it.
    `CHA_ASSERT_RESET(a_reset_empty, !aresetn, !m_tvalid, "result valid after reset")

endmodule

bind compass_heading_atan2_core cha_checker u_cha_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
